// File: rtl/cpc_pkg.sv
// Shared constants, codes and pipeline stage type for the channel polynomial correction block.
package cpc_pkg;

   localparam int CHANNELS  = 16384;
   localparam int MAX_TERMS = 4;

   localparam int CHAN_W   = 14;
   localparam int TERM_W   = 2;
   localparam int COEF_W   = 32;
   localparam int SAMPLE_W = 16;
   localparam int FRAC_W   = 16;
   localparam int PROD_W   = COEF_W + SAMPLE_W;
   localparam int SUM_W    = PROD_W + 1;

   // Horner steps after the top coefficient, two stages each (multiply, add/clip)
   localparam int STEPS  = MAX_TERMS - 1;
   localparam int NST    = 2 * STEPS;
   localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam logic signed [SUM_W-1:0] Q_MAX = SUM_W'(64'sd2147483647);
   localparam logic signed [SUM_W-1:0] Q_MIN = -SUM_W'(64'sd2147483648);

   typedef enum logic {
      REQ_WRITE  = 1'b0,
      REQ_SAMPLE = 1'b1
   } req_code_type;

   typedef struct packed {
      logic [CHAN_W-1:0]                     chan;
      logic signed [SAMPLE_W-1:0]            x;
      logic                                  en;
      logic                                  ok;
      logic                                  sat;
      logic signed [COEF_W-1:0]              acc;
      logic signed [PROD_W-1:0]              prod;
      logic [MAX_TERMS-1:0][COEF_W-1:0]      coef;
   } stage_type;

endpackage

// File: rtl/cpc_if.sv
// Handshake interfaces for the request, response and configuration channels.
interface cpc_req_if;
   import cpc_pkg::*;
   logic                        valid;
   logic                        ready;
   req_code_type                req_type;
   logic [CHAN_W-1:0]           channel;
   logic [TERM_W-1:0]           term_index;
   logic signed [COEF_W-1:0]    coefficient;
   logic signed [SAMPLE_W-1:0]  sample;

   modport source (output valid, req_type, channel, term_index, coefficient, sample,
                   input ready);
   modport sink   (input valid, req_type, channel, term_index, coefficient, sample,
                   output ready);
endinterface

interface cpc_rsp_if;
   import cpc_pkg::*;
   logic                        valid;
   logic                        ready;
   logic [CHAN_W-1:0]           out_channel;
   logic signed [COEF_W-1:0]    corrected;
   logic                        saturated;

   modport source (output valid, out_channel, corrected, saturated, input ready);
   modport sink   (input valid, out_channel, corrected, saturated, output ready);
endinterface

interface cpc_csr_if;
   logic valid;
   logic ready;
   logic align_enable;

   modport source (output valid, align_enable, input ready);
   modport sink   (input valid, align_enable, output ready);
endinterface

// File: rtl/cpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cpc_ram #(
   parameter int  WIDTH = 32,
   parameter int  DEPTH = 16384,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/channel_polynomial_correction.sv
// Top level: per-channel polynomial correction with coefficient RAMs and a Horner pipeline.
//
//   channel | dir | transfer when        | carries
//   --------+-----+----------------------+------------------------------------------
//   req     | in  | req.valid & ready    | req_type, channel, term_index, coefficient,
//           |     |                      | sample
//   rsp     | out | rsp.valid & ready    | out_channel, corrected, saturated
//   csr     | in  | csr.valid (ready = 1)| align_enable
//
// One transfer per cycle on req while req.ready is high. Write transfers finish at the accept
// edge; a sample's RAM read lands in stage 0 at the accept edge, then it passes through a
// multiply stage and an add/clip stage per Horner step, and its result is offered on rsp
// from the last stage.
// After reset a clearing pass zeroes the coefficient RAMs one channel row per cycle,
// over all CHANNELS rows (16384); req.ready stays low meanwhile, csr writes are taken.
// Each stage holds while the one after it is full and stalled; bubbles close up, so
// req keeps being taken while a finished result waits on rsp, until every stage is full.
module channel_polynomial_correction (
   input  logic      clock,
   input  logic      reset,
   cpc_req_if.sink   req,
   cpc_rsp_if.source rsp,
   cpc_csr_if.sink   csr
);
   import cpc_pkg::*;

   // configuration
   logic align_ff;

   // clearing pass
   logic              clear_ff;
   logic [ADDR_W-1:0] clr_row_ff;

   // pipeline
   logic      [NST:0] v_ff;
   stage_type         st_ff  [NST+1];
   stage_type         st_cur [NST+1];
   stage_type         st_in  [NST+1];
   logic      [NST:0] take;
   logic      [NST:0] move;

   // request decode
   logic              req_fire;
   logic              wr_fire;
   logic              smp_fire;
   logic              chan_ok;
   logic              term_ok;
   logic [ADDR_W-1:0] req_addr;

   // RAM ports
   logic [MAX_TERMS-1:0]             ram_we;
   logic [ADDR_W-1:0]                ram_waddr;
   logic [COEF_W-1:0]                ram_wdata;
   logic [MAX_TERMS-1:0][COEF_W-1:0] ram_rdata;

   assign chan_ok  = (int'(req.channel) < CHANNELS);
   assign term_ok  = (int'(req.term_index) < MAX_TERMS);
   assign req_addr = ADDR_W'(req.channel);

   assign req.ready = !clear_ff && take[0];
   assign req_fire  = req.valid && req.ready;
   assign wr_fire   = req_fire && (req.req_type == REQ_WRITE) && chan_ok && term_ok;
   assign smp_fire  = req_fire && (req.req_type == REQ_SAMPLE);

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         align_ff <= 1'b0;
      end else if (csr.valid) begin
         align_ff <= csr.align_enable;
      end
   end

   // clearing sweep, one row of all term RAMs per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff   <= 1'b1;
         clr_row_ff <= '0;
      end else if (clear_ff) begin
         clr_row_ff <= clr_row_ff + 1'b1;
         if (clr_row_ff == ADDR_W'(CHANNELS - 1)) begin
            clear_ff <= 1'b0;
         end
      end
   end

   assign ram_waddr = clear_ff ? clr_row_ff : req_addr;
   assign ram_wdata = clear_ff ? '0 : req.coefficient;

   // one RAM per term, all read at once at the sample's channel
   for (genvar j = 0; j < MAX_TERMS; j++) begin : g_term
      assign ram_we[j] = clear_ff || (wr_fire && (int'(req.term_index) == j));

      cpc_ram #(
         .WIDTH (COEF_W),
         .DEPTH (CHANNELS)
      ) u_ram (
         .clock (clock),
         .we    (ram_we[j]),
         .waddr (ram_waddr),
         .wdata (ram_wdata),
         .re    (take[0]),
         .raddr (req_addr),
         .rdata (ram_rdata[j])
      );
   end

   // flow control: a stage takes new data when empty or when it moves on
   always_comb begin
      for (int s = NST; s >= 0; s--) begin
         if (s == NST) begin
            move[s] = v_ff[s] && rsp.ready;
         end else begin
            move[s] = v_ff[s] && take[s+1];
         end
         take[s] = !v_ff[s] || move[s];
      end
   end

   // stage 0 view: side fields from registers, coefficients straight from the RAMs;
   // an out-of-range channel sees all coefficients as zero
   always_comb begin
      st_cur[0] = st_ff[0];
      for (int j = 0; j < MAX_TERMS; j++) begin
         st_cur[0].coef[j] = st_ff[0].ok ? ram_rdata[j] : '0;
      end
      st_cur[0].acc = $signed(st_cur[0].coef[MAX_TERMS-1]);
   end

   for (genvar s = 1; s <= NST; s++) begin : g_view
      assign st_cur[s] = st_ff[s];
   end

   // stage 0 load from the request
   always_comb begin
      st_in[0]      = '0;
      st_in[0].chan = req.channel;
      st_in[0].x    = req.sample;
      st_in[0].en   = align_ff;
      st_in[0].ok   = chan_ok;
   end

   // Horner stages: odd stage multiplies acc by x, even stage adds the next
   // coefficient and clips to signed 32 bits
   for (genvar s = 1; s <= NST; s++) begin : g_stage
      if ((s % 2) == 1) begin : g_mul
         always_comb begin
            st_in[s]      = st_cur[s-1];
            st_in[s].prod = st_cur[s-1].acc * st_cur[s-1].x;
         end
      end else begin : g_add
         localparam int K = MAX_TERMS - 1 - (s / 2);
         logic signed [SUM_W-1:0] sum;
         assign sum = SUM_W'(st_cur[s-1].prod) + SUM_W'($signed(st_cur[s-1].coef[K]));
         always_comb begin
            st_in[s] = st_cur[s-1];
            if (sum > Q_MAX) begin
               st_in[s].acc = COEF_W'(Q_MAX);
               st_in[s].sat = 1'b1;
            end else if (sum < Q_MIN) begin
               st_in[s].acc = COEF_W'(Q_MIN);
               st_in[s].sat = 1'b1;
            end else begin
               st_in[s].acc = COEF_W'(sum);
            end
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int s = 0; s <= NST; s++) begin
            if (take[s]) begin
               if (s == 0) begin
                  v_ff[s] <= smp_fire;
               end else begin
                  v_ff[s] <= v_ff[s-1];
               end
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      for (int s = 0; s <= NST; s++) begin
         if (take[s]) begin
            st_ff[s] <= st_in[s];
         end
      end
   end

   // result: pass-through scales the raw sample to Q16.16
   assign rsp.valid       = v_ff[NST];
   assign rsp.out_channel = st_cur[NST].chan;
   assign rsp.corrected   = st_cur[NST].en ? st_cur[NST].acc
                                           : {st_cur[NST].x, FRAC_W'(0)};
   assign rsp.saturated   = st_cur[NST].en && st_cur[NST].sat;

endmodule
